// File: rtl/ssme_pkg.sv
package ssme_pkg;

  // Input mode codes.
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_START  = 2'd2;

  // Operation codes carried by a start request.
  localparam logic [1:0] OP_UNION     = 2'd0;
  localparam logic [1:0] OP_INTERSECT = 2'd1;
  localparam logic [1:0] OP_DIFF      = 2'd2;

  // One input request.
  typedef struct packed {
    logic [1:0]          mode;
    logic signed [31:0]  value;
    logic [1:0]          operation;
  } in_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0]  result_value;
    logic                last;
    logic                empty_res;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_a;
    logic load_b;
    logic start;
    logic step;
    logic finish;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
    logic need_slot;
    logic slot_free;
  } dp_stat_t;

endpackage

// File: rtl/ssme_dp.sv
module ssme_dp #(
  parameter int LIST_LEN = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssme_pkg::ctrl_cmd_t cmd,
  input  ssme_pkg::in_t      in_data,
  input  logic               out_ready,
  output ssme_pkg::dp_stat_t stat,
  output logic               out_valid,
  output ssme_pkg::out_t     out_data
);

  localparam int AW = (LIST_LEN > 1) ? $clog2(LIST_LEN) : 1;
  localparam int PW = $clog2(LIST_LEN + 1);
  localparam logic [PW-1:0] LEN_P    = PW'(LIST_LEN);
  localparam logic [AW-1:0] LAST_IDX = AW'(LIST_LEN - 1);

  // List storage, one write port and one registered read port each.
  logic signed [31:0] mem_a [LIST_LEN];
  logic signed [31:0] mem_b [LIST_LEN];
  logic signed [31:0] rd_a_r;
  logic signed [31:0] rd_b_r;

  logic [AW-1:0] lidx_a_r, lidx_a_nxt;
  logic [AW-1:0] lidx_b_r, lidx_b_nxt;
  logic [PW-1:0] ptr_a_r, ptr_a_nxt;
  logic [PW-1:0] ptr_b_r, ptr_b_nxt;
  logic [1:0]    op_r;

  logic signed [31:0] hold_r;
  logic               hold_valid_r;
  ssme_pkg::out_t     out_r;
  logic               out_valid_r;

  logic               a_has, b_has;
  logic               emit, adv_a, adv_b, done;
  logic signed [31:0] emit_val;
  logic               push;

  // Load slots wrap at the end of the list.
  assign lidx_a_nxt = (lidx_a_r == LAST_IDX) ? '0 : lidx_a_r + AW'(1);
  assign lidx_b_nxt = (lidx_b_r == LAST_IDX) ? '0 : lidx_b_r + AW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lidx_a_r <= '0;
      lidx_b_r <= '0;
    end else if (cmd.start) begin
      lidx_a_r <= '0;
      lidx_b_r <= '0;
    end else begin
      if (cmd.load_a) lidx_a_r <= lidx_a_nxt;
      if (cmd.load_b) lidx_b_r <= lidx_b_nxt;
    end
  end

  // Memories: write on load, read at the pointer's next position.
  always_ff @(posedge clk) begin
    if (cmd.load_a) mem_a[lidx_a_r] <= in_data.value;
    if (cmd.load_b) mem_b[lidx_b_r] <= in_data.value;
    rd_a_r <= mem_a[ptr_a_nxt[AW-1:0]];
    rd_b_r <= mem_b[ptr_b_nxt[AW-1:0]];
  end

  // One merge step: compare the current heads and pick what to emit.
  assign a_has = (ptr_a_r != LEN_P);
  assign b_has = (ptr_b_r != LEN_P);

  always_comb begin
    emit     = 1'b0;
    emit_val = rd_a_r;
    adv_a    = 1'b0;
    adv_b    = 1'b0;
    done     = 1'b0;
    if (a_has && b_has) begin
      if (rd_a_r < rd_b_r) begin
        emit  = (op_r != ssme_pkg::OP_INTERSECT);
        adv_a = 1'b1;
      end else if (rd_a_r > rd_b_r) begin
        emit     = (op_r == ssme_pkg::OP_UNION);
        emit_val = rd_b_r;
        adv_b    = 1'b1;
      end else begin
        emit  = (op_r != ssme_pkg::OP_DIFF);
        adv_a = 1'b1;
        adv_b = 1'b1;
      end
    end else if (a_has && (op_r != ssme_pkg::OP_INTERSECT)) begin
      emit  = 1'b1;
      adv_a = 1'b1;
    end else if (b_has && (op_r == ssme_pkg::OP_UNION)) begin
      emit     = 1'b1;
      emit_val = rd_b_r;
      adv_b    = 1'b1;
    end else begin
      done = 1'b1;
    end
  end

  // Pointer update.
  always_comb begin
    ptr_a_nxt = ptr_a_r;
    ptr_b_nxt = ptr_b_r;
    if (cmd.start) begin
      ptr_a_nxt = '0;
      ptr_b_nxt = '0;
    end else if (cmd.step) begin
      if (adv_a) ptr_a_nxt = ptr_a_r + PW'(1);
      if (adv_b) ptr_b_nxt = ptr_b_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_a_r <= '0;
      ptr_b_r <= '0;
    end else begin
      ptr_a_r <= ptr_a_nxt;
      ptr_b_r <= ptr_b_nxt;
    end
    if (cmd.start) op_r <= in_data.operation;
  end

  // The newest emitted word waits in the hold register until it is known
  // whether another follows, so that the final one can be marked.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (cmd.start || cmd.finish) begin
      hold_valid_r <= 1'b0;
    end else if (cmd.step && emit) begin
      hold_valid_r <= 1'b1;
    end
    if (cmd.step && emit) hold_r <= emit_val;
  end

  // Output register.
  assign push = (cmd.step && emit && hold_valid_r) || cmd.finish;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.finish) begin
      if (hold_valid_r) begin
        out_r.result_value <= hold_r;
        out_r.empty_res    <= 1'b0;
      end else begin
        out_r.result_value <= '0;
        out_r.empty_res    <= 1'b1;
      end
      out_r.last <= 1'b1;
    end else if (push) begin
      out_r.result_value <= hold_r;
      out_r.last         <= 1'b0;
      out_r.empty_res    <= 1'b0;
    end
  end

  assign stat.done      = done;
  assign stat.need_slot = emit && hold_valid_r;
  assign stat.slot_free = !out_valid_r || out_ready;
  assign out_valid      = out_valid_r;
  assign out_data       = out_r;

endmodule

// File: rtl/ssme_ctrl.sv
module ssme_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  ssme_pkg::in_t       in_data,
  input  ssme_pkg::dp_stat_t  stat,
  output logic                in_ready,
  output ssme_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MERGE,
    ST_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   acc;
  logic   op_ok;

  assign in_ready = (state_r == ST_IDLE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    case (in_data.operation) inside
      ssme_pkg::OP_UNION, ssme_pkg::OP_INTERSECT, ssme_pkg::OP_DIFF: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  // Command decode and next state.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        cmd.load_a = acc && (in_data.mode == ssme_pkg::MODE_LOAD_A);
        cmd.load_b = acc && (in_data.mode == ssme_pkg::MODE_LOAD_B);
        cmd.start  = acc && (in_data.mode == ssme_pkg::MODE_START) && op_ok;
        if (cmd.start) state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        // A step that pushes a word out waits for a free output slot.
        if (stat.done) begin
          state_nxt = ST_FINISH;
        end else begin
          cmd.step = !stat.need_slot || stat.slot_free;
        end
      end
      ST_FINISH: begin
        cmd.finish = stat.slot_free;
        if (stat.slot_free) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/sorted_set_merge_engine.sv
// Loads: one request per cycle, accepted back to back while idle.
// Start: one merge step per cycle (one read of each list memory port),
// except while an output stall holds a step back.
// A step that must move the held word on while the output register is full
// waits for it to drain.
// Reset (rst_n low, synchronous) clears the controller, pointers and load
// slots and empties the output; list contents are undefined until loaded.
module sorted_set_merge_engine #(
  parameter int LIST_LEN = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  ssme_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output ssme_pkg::out_t out_data
);

  ssme_pkg::ctrl_cmd_t cmd;
  ssme_pkg::dp_stat_t  stat;

  // Sequencer.
  ssme_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_data  (in_data),
    .stat     (stat),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  // Lists, pointers, comparator and output register.
  ssme_dp #(
    .LIST_LEN (LIST_LEN)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: rtl/ssme_chk.sv
module ssme_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input ssme_pkg::in_t  in_data,
  input logic           out_valid,
  input logic           out_ready,
  input ssme_pkg::out_t out_data
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // An empty result is always the final one.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.last)
    else $error("empty result not marked last");

  // An empty result carries a zero word.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |-> out_data.result_value == 32'sd0)
    else $error("empty result with non-zero value");

  // A valid start makes the block busy on the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.mode == ssme_pkg::MODE_START) &&
    ((in_data.operation == ssme_pkg::OP_UNION) ||
     (in_data.operation == ssme_pkg::OP_INTERSECT) ||
     (in_data.operation == ssme_pkg::OP_DIFF)) |=> !in_ready)
    else $error("input still ready after a start");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind sorted_set_merge_engine ssme_chk u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sorted_set_merge_engine_tb.sv
`timescale 1ns / 100ps

module sorted_set_merge_engine_tb;

  localparam int LIST_LEN     = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * LIST_LEN + 8;
  localparam int CYCLE_LIMIT  = 200000;

  // Codes that the package leaves unnamed; the block must ignore both.
  localparam logic [1:0] MODE_UNKNOWN = 2'd3;
  localparam logic [1:0] OP_UNKNOWN   = 2'd3;

  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7fff_ffff;

  logic           clk       = 1'b0;
  logic           rst_n     = 1'b0;
  logic           in_valid  = 1'b0;
  logic           in_ready;
  ssme_pkg::in_t  in_data   = '0;
  logic           out_valid;
  logic           out_ready = 1'b0;
  ssme_pkg::out_t out_data;

  // Own copy of the two lists and their load slots.
  logic signed [31:0] list_a_copy [LIST_LEN];
  logic signed [31:0] list_b_copy [LIST_LEN];
  int                 fill_a = 0;
  int                 fill_b = 0;

  // Merge words still owed by the block, oldest first.
  ssme_pkg::out_t owed_words [$];
  int unsigned    word_errors       = 0;
  int unsigned    accepted_requests = 0;
  int unsigned    cycle_count       = 0;

  // Idle rates in percent, and the long hold-off of the result side.
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req    = 0;
  int hold_ack    = 0;
  int hold_left   = 0;

  sorted_set_merge_engine #(
    .LIST_LEN (LIST_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #10 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off each time one is requested.
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Compare each accepted result with the oldest word owed.
  always @(posedge clk) begin : compare_results
    ssme_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_words.size() == 0) begin
        $error("result with nothing outstanding: result_value %0d last %0b empty_res %0b",
               out_data.result_value, out_data.last, out_data.empty_res);
        word_errors++;
      end else begin
        want = owed_words.pop_front();
        // The word carries no meaning on an empty result.
        if (!want.empty_res && out_data.result_value !== want.result_value) begin
          $error("result_value: expected %0d, got %0d",
                 want.result_value, out_data.result_value);
          word_errors++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_data.last);
          word_errors++;
        end
        if (out_data.empty_res !== want.empty_res) begin
          $error("empty_res: expected %0b, got %0b", want.empty_res, out_data.empty_res);
          word_errors++;
        end
      end
    end
  end

  // Update the list copies for one accepted request and queue the words it owes.
  function automatic void apply_request(ssme_pkg::in_t req);
    int                 ia;
    int                 ib;
    logic signed [31:0] words [$];
    ssme_pkg::out_t     r;
    ia = 0;
    ib = 0;
    case (req.mode)
      ssme_pkg::MODE_LOAD_A: begin
        list_a_copy[fill_a] = req.value;
        fill_a = (fill_a + 1 >= LIST_LEN) ? 0 : fill_a + 1;
      end
      ssme_pkg::MODE_LOAD_B: begin
        list_b_copy[fill_b] = req.value;
        fill_b = (fill_b + 1 >= LIST_LEN) ? 0 : fill_b + 1;
      end
      ssme_pkg::MODE_START: begin
        if (req.operation != OP_UNKNOWN) begin
          // Two-pointer walk with a signed comparison per step.
          while (ia < LIST_LEN && ib < LIST_LEN) begin
            if (list_a_copy[ia] < list_b_copy[ib]) begin
              if (req.operation != ssme_pkg::OP_INTERSECT) words.push_back(list_a_copy[ia]);
              ia++;
            end else if (list_a_copy[ia] > list_b_copy[ib]) begin
              if (req.operation == ssme_pkg::OP_UNION) words.push_back(list_b_copy[ib]);
              ib++;
            end else begin
              if (req.operation != ssme_pkg::OP_DIFF) words.push_back(list_a_copy[ia]);
              ia++;
              ib++;
            end
          end
          // Tails once one list has run out.
          if (req.operation != ssme_pkg::OP_INTERSECT) begin
            while (ia < LIST_LEN) begin
              words.push_back(list_a_copy[ia]);
              ia++;
            end
          end
          if (req.operation == ssme_pkg::OP_UNION) begin
            while (ib < LIST_LEN) begin
              words.push_back(list_b_copy[ib]);
              ib++;
            end
          end
          if (words.size() == 0) begin
            r.result_value = '0;
            r.last         = 1'b1;
            r.empty_res    = 1'b1;
            owed_words.push_back(r);
          end else begin
            foreach (words[i]) begin
              r.result_value = words[i];
              r.last         = (i == int'(words.size()) - 1);
              r.empty_res    = 1'b0;
              owed_words.push_back(r);
            end
          end
          fill_a = 0;
          fill_b = 0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic ssme_pkg::in_t make_req(logic [1:0] mode, logic [31:0] value,
                                             logic [1:0] op);
    ssme_pkg::in_t r;
    r.mode      = mode;
    r.value     = value;
    r.operation = op;
    return r;
  endfunction

  // Next word of an ascending list, saturating at the top; now and then a wild word.
  function automatic logic signed [31:0] step_word(logic signed [31:0] cur,
                                                   int unsigned span, bit shuffle);
    longint sum;
    if (shuffle && $urandom_range(9) == 0) return $urandom;
    sum = longint'(cur) + longint'($urandom_range(span, 0));
    if (sum > longint'(WORD_MAX)) return WORD_MAX;
    return sum[31:0];
  endfunction

  // Offer one request, with a random gap first, and wait for its handshake.
  task automatic send_req(ssme_pkg::in_t req);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    apply_request(req);
    accepted_requests++;
  endtask

  // Hold the request side idle until every owed word has come out.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (owed_words.size() != 0);
  endtask

  // Extremes, every operation, wrap of the load slot, ignored codes, empty result.
  task automatic test_directed();
    logic signed [31:0] a_words [8];
    logic signed [31:0] b_words [8];
    a_words = '{-5, -1, 0, 3, 7, 100, WORD_MAX, WORD_MIN};
    b_words = '{-6, -5, -1, 0, 3, 7, 100, WORD_MAX};
    // The first word lands in slot 0 and is overwritten by the ninth load.
    send_req(make_req(ssme_pkg::MODE_LOAD_A, 32'sd12345, ssme_pkg::OP_UNION));
    for (int i = 0; i < 8; i++) begin
      // A start with an unknown operation must leave the load slot alone.
      if (i == 4) send_req(make_req(ssme_pkg::MODE_START, 32'sd0, OP_UNKNOWN));
      send_req(make_req(ssme_pkg::MODE_LOAD_A, a_words[i], OP_UNKNOWN));
    end
    for (int i = 0; i < 8; i++) begin
      if (i == 4) send_req(make_req(MODE_UNKNOWN, 32'sd77, ssme_pkg::OP_INTERSECT));
      send_req(make_req(ssme_pkg::MODE_LOAD_B, b_words[i], ssme_pkg::OP_DIFF));
    end
    send_req(make_req(ssme_pkg::MODE_START, WORD_MAX, ssme_pkg::OP_UNION));
    send_req(make_req(ssme_pkg::MODE_START, WORD_MIN, ssme_pkg::OP_INTERSECT));
    send_req(make_req(ssme_pkg::MODE_START, 32'sd0, ssme_pkg::OP_DIFF));
    // After a start the next load goes to slot 0 again; A then equals B.
    send_req(make_req(ssme_pkg::MODE_LOAD_A, -32'sd6, ssme_pkg::OP_UNION));
    send_req(make_req(ssme_pkg::MODE_START, -32'sd1, ssme_pkg::OP_DIFF));
    wait_results_drained();
  endtask

  // One pair of list loads, interleaved at random, then a start; or, in one style, one to three noise requests instead.
  task automatic run_round();
    int                 style;
    int unsigned        span;
    bit                 shuffle;
    int                 count_a;
    int                 count_b;
    int                 sent_a;
    int                 sent_b;
    logic signed [31:0] cur_a;
    logic signed [31:0] cur_b;
    logic [1:0]         op;
    style   = $urandom_range(3);
    shuffle = ($urandom_range(9) == 0);
    sent_a  = 0;
    sent_b  = 0;
    case (style)
      0: begin
        // Dense values near zero: many equal words and duplicates.
        cur_a = int'($urandom_range(20)) - 10;
        span  = 3;
      end
      1: begin
        cur_a = $urandom;
        span  = 1 << $urandom_range(26);
      end
      2: begin
        cur_a = ($urandom_range(1) == 0) ? WORD_MIN : WORD_MAX - 40;
        span  = 8;
      end
      default: begin
        // A few requests of plain noise instead of a well-formed sequence.
        repeat ($urandom_range(3, 1)) begin
          send_req(make_req(2'($urandom_range(3)), $urandom, 2'($urandom_range(3))));
        end
        return;
      end
    endcase
    cur_b   = cur_a;
    count_a = ($urandom_range(4) == 0) ? $urandom_range(LIST_LEN + 3, 1) : LIST_LEN;
    count_b = ($urandom_range(4) == 0) ? $urandom_range(LIST_LEN + 3, 1) : LIST_LEN;
    while (sent_a < count_a || sent_b < count_b) begin
      if (sent_b >= count_b || (sent_a < count_a && $urandom_range(1) == 1)) begin
        cur_a = step_word(cur_a, span, shuffle);
        send_req(make_req(ssme_pkg::MODE_LOAD_A, cur_a, 2'($urandom_range(3))));
        sent_a++;
      end else begin
        cur_b = step_word(cur_b, span, shuffle);
        send_req(make_req(ssme_pkg::MODE_LOAD_B, cur_b, 2'($urandom_range(3))));
        sent_b++;
      end
      if ($urandom_range(24) == 0) begin
        send_req(make_req(MODE_UNKNOWN, $urandom, 2'($urandom_range(3))));
      end
    end
    op = ($urandom_range(9) == 0) ? OP_UNKNOWN : 2'($urandom_range(2));
    send_req(make_req(ssme_pkg::MODE_START, $urandom, op));
  endtask

  // Random rounds under the given idle rates of the two sides.
  task automatic test_random_traffic(int tx_pct, int rx_pct);
    int unsigned stop_at;
    stop_at     = accepted_requests + 40;
    tx_idle_pct = tx_pct;
    rx_idle_pct <= rx_pct;
    while (accepted_requests < stop_at) run_round();
    wait_results_drained();
  endtask

  // The result side holds off for a long stretch while requests keep coming.
  task automatic test_output_stall();
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    hold_req    <= hold_req + 1;
    // A union always owes several words, so the block fills up.
    send_req(make_req(ssme_pkg::MODE_START, 32'sd0, ssme_pkg::OP_UNION));
    run_round();
    run_round();
    run_round();
    wait_results_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_traffic(24, 46);
    test_random_traffic(46, 24);
    test_random_traffic(0, 0);
    test_output_stall();
    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (word_errors == 0 && owed_words.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/ssme_pkg.sv
rtl/ssme_dp.sv
rtl/ssme_ctrl.sv
rtl/sorted_set_merge_engine.sv
rtl/ssme_chk.sv
tb/sorted_set_merge_engine_tb.sv
